// File: sv/phist_pkg.sv
// Package for the pixel histogram engine: sizes, opcodes and the
// controller/datapath command and status structs.
// No dependencies.
package phist_pkg;

  // Bin store geometry
  localparam int BINS       = 256;
  localparam int COUNT_BITS = 20;
  localparam int BIN_AW     = $clog2(BINS);

  // Item field widths
  localparam int OPCODE_W    = 2;
  localparam int VALUE_W     = 8;
  localparam int OUT_COUNT_W = 20;

  // Stream packing, padded to whole bytes
  localparam int IN_FIELDS_W  = OPCODE_W + VALUE_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VALUE_W + OUT_COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  // Register reset value
  localparam logic [VALUE_W-1:0] MAX_LEVEL_RST = 8'd255;

  // Opcodes
  localparam logic [OPCODE_W-1:0] OP_ACCUM    = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_READ     = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_READ_CLR = 2'd2;

  // Controller to datapath
  typedef struct packed {
    logic              rd_en;    // take the input item, issue bin read
    logic              upd_en;   // finish the item: write back, load result
    logic              clr_en;   // clearing pass write
    logic [BIN_AW-1:0] clr_addr; // clearing pass address
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic needs_out;   // held item produces a result
    logic out_blocked; // result register full and not drained this cycle
  } sts_t;

endpackage

// File: sv/phist_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module phist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port; read data holds when idle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: sv/phist_ctrl.sv
// Controller for the pixel histogram: clearing pass after reset, then a
// two-step sequence per item (bin read, then update and result load).
// Depends on phist_pkg.
module phist_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  phist_pkg::sts_t     sts,
  output phist_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t                      state_r, state_nxt;
  logic [phist_pkg::BIN_AW-1:0] clr_addr_r, clr_addr_nxt;
  logic                        clr_last;
  logic                        exec_go;

  assign clr_last = (clr_addr_r == phist_pkg::BIN_AW'(phist_pkg::BINS - 1));
  // Item can finish unless its result has nowhere to go
  assign exec_go  = !(sts.needs_out && sts.out_blocked);

  // Next state and commands
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cmd          = '0;
    cmd.clr_addr = clr_addr_r;
    in_tready    = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_en   = 1'b1;
        clr_addr_nxt = clr_addr_r + phist_pkg::BIN_AW'(1);
        if (clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_tready  = 1'b1;
        cmd.rd_en  = in_tvalid;
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.upd_en = exec_go;
        if (exec_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // State and sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

endmodule

// File: sv/phist_dp.sv
// Datapath for the pixel histogram: item registers, bin RAM, saturating
// increment, max_level register and the result register.
// Depends on phist_pkg and phist_ram.
module phist_dp (
  input  logic                                clk,
  input  logic                                rst_n,
  input  phist_pkg::cmd_t                     cmd,
  output phist_pkg::sts_t                     sts,
  input  logic [phist_pkg::IN_TDATA_W-1:0]    in_tdata,
  input  logic                                cfg_wr_en,
  input  logic [phist_pkg::VALUE_W-1:0]       cfg_wr_data,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [phist_pkg::OUT_TDATA_W-1:0]   out_tdata
);

  logic [phist_pkg::OPCODE_W-1:0]    in_opcode;
  logic [phist_pkg::VALUE_W-1:0]     in_value;
  logic [phist_pkg::OPCODE_W-1:0]    op_r;
  logic [phist_pkg::VALUE_W-1:0]     value_r;
  logic [phist_pkg::VALUE_W-1:0]     max_level_r;
  logic [phist_pkg::COUNT_BITS-1:0]  rdata;
  logic                              ram_we;
  logic [phist_pkg::BIN_AW-1:0]      ram_waddr;
  logic [phist_pkg::COUNT_BITS-1:0]  ram_wdata;
  logic                              in_store;
  logic                              acc_ok;
  logic                              saturated;
  logic                              load_out;
  logic [phist_pkg::OUT_COUNT_W-1:0] rd_count;
  logic                              out_tvalid_r;
  logic [phist_pkg::VALUE_W-1:0]     out_index_r;
  logic [phist_pkg::OUT_COUNT_W-1:0] out_count_r;

  // Unpack input transfer
  assign in_opcode = in_tdata[phist_pkg::OPCODE_W-1:0];
  assign in_value  = in_tdata[phist_pkg::IN_FIELDS_W-1:phist_pkg::OPCODE_W];

  // Hold the item while its bin is read
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      op_r    <= in_opcode;
      value_r <= in_value;
    end
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_level_r <= phist_pkg::MAX_LEVEL_RST;
    end else if (cfg_wr_en) begin
      max_level_r <= cfg_wr_data;
    end
  end

  phist_ram #(
    .WIDTH (phist_pkg::COUNT_BITS),
    .DEPTH (phist_pkg::BINS)
  ) u_bins (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd_en),
    .raddr (phist_pkg::BIN_AW'(in_value)),
    .rdata (rdata)
  );

  // Bin qualification and saturation
  assign in_store  = (32'(value_r) < 32'(phist_pkg::BINS));
  assign acc_ok    = in_store && (value_r <= max_level_r);
  assign saturated = (rdata == '1);

  // Write-back: clearing sweep, increment or clear-after-read
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = phist_pkg::BIN_AW'(value_r);
    ram_wdata = rdata + phist_pkg::COUNT_BITS'(1);
    if (cmd.clr_en) begin
      ram_we    = 1'b1;
      ram_waddr = cmd.clr_addr;
      ram_wdata = '0;
    end else if (cmd.upd_en) begin
      case (op_r)
        phist_pkg::OP_ACCUM: begin
          ram_we = acc_ok && !saturated;
        end
        phist_pkg::OP_READ_CLR: begin
          ram_we    = in_store;
          ram_wdata = '0;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  // Result register
  assign sts.needs_out   = (op_r == phist_pkg::OP_READ) || (op_r == phist_pkg::OP_READ_CLR);
  assign sts.out_blocked = out_tvalid_r && !out_tready;
  assign load_out        = cmd.upd_en && sts.needs_out;
  assign rd_count        = in_store ? phist_pkg::OUT_COUNT_W'(rdata) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_tvalid_r <= 1'b0;
    end else if (load_out) begin
      out_tvalid_r <= 1'b1;
    end else if (out_tready) begin
      out_tvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_index_r <= value_r;
      out_count_r <= rd_count;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{phist_pkg::OUT_PAD_W{1'b0}}, out_count_r, out_index_r};

endmodule

// File: sv/pixel_histogram.sv
// Pixel histogram engine, top level.
// A new item is taken only after the last one's bin RAM read and write-back,
// which stalls while an earlier read result waits; results are registered.
// Reset: synchronous, active low; max_level returns to 255, then a clearing
// pass zeroes all 256 bins with in_tready held low.
// Depends on phist_pkg, phist_ctrl, phist_dp, phist_ram.
module pixel_histogram (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [phist_pkg::IN_TDATA_W-1:0]  in_tdata,   // opcode[1:0], value[9:2]
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [phist_pkg::OUT_TDATA_W-1:0] out_tdata,  // bin_index[7:0], bin_count[27:8]
  input  logic                              cfg_wr_en,
  input  logic [phist_pkg::VALUE_W-1:0]     cfg_wr_data // max_level
);

  phist_pkg::cmd_t cmd;
  phist_pkg::sts_t sts;

  phist_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  phist_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_tdata    (in_tdata),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_tready  (out_tready),
    .out_tvalid  (out_tvalid),
    .out_tdata   (out_tdata)
  );

  // An accepted item is followed by its update step, not another transfer
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_en |=> !in_tready)
    else $error("input taken while previous item in flight");

  // No input transfer during the clearing pass
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clr_en |-> !(in_tvalid && in_tready))
    else $error("input transfer during clearing pass");

  // A new result only appears after an update step
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(cmd.upd_en))
    else $error("result without update step");

  // Update never overwrites a result that is still waiting
  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.upd_en && sts.needs_out) |-> !(out_tvalid && !out_tready))
    else $error("pending result overwritten");

endmodule
